/* rtl/core/grid_min_range_path_unit_defines.svh */
// Assertion macros for the grid min-range path unit
`ifndef GRID_MIN_RANGE_PATH_UNIT_DEFINES_SVH
`define GRID_MIN_RANGE_PATH_UNIT_DEFINES_SVH

// same-cycle implication
`define GMRP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GMRP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/gmrp_pkg.sv */
// ----------------------------------------------------------------------------
// gmrp_pkg
// Shared types and constants for the grid min-range path unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gmrp_pkg;
  typedef logic [8:0] level_t;
  typedef logic [7:0] height_t;
  localparam level_t UNREACHED = 9'h1FF;
endpackage
`default_nettype wire

/* rtl/core/grid_min_range_path_unit.sv */
// ----------------------------------------------------------------------------
// grid_min_range_path_unit
// Loads a height grid and finds the smallest max-minus-bound path range.
// ----------------------------------------------------------------------------
// Cells load one per cycle. After the last cell, each bound 0..MAX_LEVEL not
// above the start cell's height runs an init pass and relaxation sweeps
// over every cell until a sweep makes no change, all through one read port
// per memory and one relax unit; input stalls until the result is registered.
// Reset (rst, synchronous) clears control state; grid_size = min(GRID_MAX, 64).
`timescale 1ns / 1ps
`default_nettype none
`include "grid_min_range_path_unit_defines.svh"
module grid_min_range_path_unit import gmrp_pkg::*; #(
  parameter int GRID_MAX  = 64,
  parameter int MAX_LEVEL = 255
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [6:0] cfg_data,           // grid_size
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,       // [7:0] cell_height
  input  wire        s_axis_tlast,       // last_cell
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,       // [7:0] min_range
  output logic       m_axis_tuser        // path_found
);
  localparam int CW  = $clog2(GRID_MAX * GRID_MAX);
  localparam int CLW = $clog2(GRID_MAX * GRID_MAX + 1);
  localparam int NW  = $clog2(GRID_MAX + 1);
  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int SIZE_RESET = 64;
  localparam int N_RESET = (GRID_MAX < SIZE_RESET) ? GRID_MAX : SIZE_RESET;

  typedef enum logic [3:0] {
    ST_IDLE, ST_H0REQ, ST_H0CAP, ST_INIT, ST_SWEEP, ST_ENDREQ, ST_ENDCAP,
    ST_NEXTB, ST_DONE
  } state_t;

  state_t         state;
  logic [NW-1:0]  n_r;
  logic [CLW-1:0] cells_r;
  logic [CLW-1:0] load_pos;
  logic [CW-1:0]  c;
  logic [NW-1:0]  row, col;
  logic [2:0]     k;
  logic           changed;
  level_t         b;
  level_t         best;
  height_t        h0, hc;
  level_t         cur, acc;

  height_t hmem [DEPTH];
  level_t  bmem [DEPTH];
  height_t hq;
  level_t  bq;
  logic [CW-1:0] hra, bra, bwa;
  level_t  bwd;
  logic    bwe, hwe;

  logic [9:0]    gs_ext;
  logic [NW-1:0] n_use;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] nsz;
  logic          v_up, v_dn, v_lf, v_rt, nb_v;
  level_t        relax_out;
  logic          s_fire, m_fire;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    gs_ext = {3'b000, cfg_data};
    if (gs_ext == 10'd0) n_use = NW'(1);
    else if (gs_ext > 10'(GRID_MAX)) n_use = NW'(GRID_MAX);
    else n_use = NW'(gs_ext);
  end

  assign last_idx = CW'(cells_r - CLW'(1));
  assign nsz  = CW'(n_r);
  assign v_up = (row != '0);
  assign v_dn = ({1'b0, row} + (NW+1)'(1)) < {1'b0, n_r};
  assign v_lf = (col != '0);
  assign v_rt = ({1'b0, col} + (NW+1)'(1)) < {1'b0, n_r};

  always_comb begin
    case (k)
      3'd2:    nb_v = v_up;
      3'd3:    nb_v = v_dn;
      3'd4:    nb_v = v_lf;
      3'd5:    nb_v = v_rt;
      default: nb_v = 1'b0;
    endcase
  end

  gmrp_relax_unit u_relax (
    .acc      (acc),
    .height   (hc),
    .neighbor (bq),
    .nb_valid (nb_v),
    .acc_out  (relax_out)
  );

  // memory addressing
  always_comb begin
    hra = c;
    bra = c;
    bwe = 1'b0;
    bwa = c;
    bwd = UNREACHED;
    hwe = s_fire && (load_pos < cells_r);
    unique case (state)
      ST_H0REQ:  hra = '0;
      ST_INIT: begin
        bwe = 1'b1;
        bwd = (c == '0) ? {1'b0, h0} : UNREACHED;
      end
      ST_SWEEP: begin
        unique case (k)
          3'd1:    bra = c - nsz;
          3'd2:    bra = c + nsz;
          3'd3:    bra = c - CW'(1);
          3'd4:    bra = c + CW'(1);
          default: bra = c;
        endcase
        if (k == 3'd5 && {1'b0, hc} >= b && relax_out < cur) begin
          bwe = 1'b1;
          bwd = relax_out;
        end
      end
      ST_ENDREQ: bra = last_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) hmem[CW'(load_pos)] <= s_axis_tdata;
    hq <= hmem[hra];
  end

  always_ff @(posedge clk) begin
    if (bwe) bmem[bwa] <= bwd;
    bq <= bmem[bra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      load_pos      <= '0;
      best          <= UNREACHED;
      m_axis_tvalid <= 1'b0;
      changed       <= 1'b0;
      k             <= '0;
      b             <= '0;
      c             <= '0;
      row           <= '0;
      col           <= '0;
      n_r           <= NW'(N_RESET);
      cells_r       <= CLW'(N_RESET * N_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_r     <= n_use;
        cells_r <= CLW'(n_use) * CLW'(n_use);
      end
      if (m_fire && state != ST_DONE) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (load_pos < cells_r) load_pos <= load_pos + CLW'(1);
            if (s_axis_tlast) begin
              state <= ST_H0REQ;
              b     <= '0;
              best  <= UNREACHED;
            end
          end
        end
        ST_H0REQ: state <= ST_H0CAP;
        ST_H0CAP: begin
          h0 <= hq;
          c  <= '0;
          state <= ({1'b0, hq} < b) ? ST_NEXTB : ST_INIT;
        end
        ST_INIT: begin
          if (c == last_idx) begin
            c <= '0; row <= '0; col <= '0; k <= '0; changed <= 1'b0;
            state <= ST_SWEEP;
          end else begin
            c <= c + CW'(1);
          end
        end
        ST_SWEEP: begin
          if (k == 3'd1) begin
            hc  <= hq;
            cur <= bq;
            acc <= bq;
          end else if (k > 3'd1 && k < 3'd5) begin
            acc <= relax_out;
          end
          if (k == 3'd5) begin
            k <= '0;
            if (c == last_idx) begin
              c <= '0; row <= '0; col <= '0;
              changed <= 1'b0;
              if (!(changed || bwe)) state <= ST_ENDREQ;
            end else begin
              if (bwe) changed <= 1'b1;
              c <= c + CW'(1);
              if (v_rt) col <= col + NW'(1);
              else begin
                col <= '0;
                row <= row + NW'(1);
              end
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_ENDREQ: state <= ST_ENDCAP;
        ST_ENDCAP: begin
          if (bq != UNREACHED && (bq - b) < best) best <= bq - b;
          state <= ST_NEXTB;
        end
        ST_NEXTB: begin
          if (b == 9'(MAX_LEVEL)) state <= ST_DONE;
          else begin
            b <= b + 9'd1;
            state <= ST_H0REQ;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= (best != UNREACHED) ? best[7:0] : 8'd0;
            m_axis_tuser  <= (best != UNREACHED);
            load_pos      <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GMRP_ASSERT_NOW(a_nopath_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'd0, "no-path result must carry zero range")
  `GMRP_ASSERT_NOW(a_sweep_decrease, clk, rst, state == ST_SWEEP && bwe, bwd < cur, "relaxation write must lower the bound")
  `GMRP_ASSERT_NEXT(a_last_starts, clk, rst, s_fire && s_axis_tlast, state == ST_H0REQ, "last cell transfer must start the search")
endmodule
`default_nettype wire

/* rtl/core/gmrp_relax_unit.sv */
// ----------------------------------------------------------------------------
// gmrp_relax_unit
// Shared max/min step: acc_out = min(acc, max(height, neighbor)) if valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gmrp_relax_unit import gmrp_pkg::*; (
  input  wire  level_t  acc,
  input  wire  height_t height,
  input  wire  level_t  neighbor,
  input  wire  logic    nb_valid,
  output level_t        acc_out
);
  level_t key;
  always_comb begin
    key = ({1'b0, height} > neighbor) ? {1'b0, height} : neighbor;
    acc_out = (nb_valid && key < acc) ? key : acc;
  end
endmodule
`default_nettype wire
